// ===== sv/dlsc_pkg.sv =====
// Shared types and constants for the directive line scanner.
`default_nettype none
package dlsc_pkg;

    localparam int OUT_COUNT_BITS = 24;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // One rewritten byte with its line flags.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       line_end;
        logic       is_directive;
    } t_res;

    // All results caused by one input item; slot 1 is used only when two is set.
    typedef struct packed {
        logic                      two;
        t_res                      res0;
        t_res                      res1;
        logic [OUT_COUNT_BITS-1:0] line_count;
    } t_entry;

endpackage
`default_nettype wire

// ===== sv/c_directive_line_scanner_unit.sv =====
// A result goes from its transferred byte into the queue, then into the output register.
// Throughput: one byte per cycle while the queue is not full; a byte opening a comment or
// splice, or a flushed lookahead byte, yields two results, sent by the output stage in turn.
// A four-entry queue between scanner and output stage absorbs such bursts and output stalls.
// Reset (synchronous, active low) returns scanner state, line count and queue to empty.
`default_nettype none
module c_directive_line_scanner_unit #(
    parameter int LINE_COUNT_BITS = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_char_byte,
    input  wire logic        i_end_of_file,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_line_end,
    output logic             o_is_directive,
    output logic [23:0]      o_line_count,
    output logic             o_run_last
);

    logic             accept;
    logic             push_req;
    logic             full;
    logic             empty;
    logic             pop;
    dlsc_pkg::t_entry entry;
    dlsc_pkg::t_entry head;

    assign o_in_ready = !full;
    assign accept     = i_in_valid && !full;

    dlsc_front #(
        .LINE_COUNT_BITS(LINE_COUNT_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_char_byte   (i_char_byte),
        .i_end_of_file (i_end_of_file),
        .o_push        (push_req),
        .o_entry       (entry)
    );

    dlsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && push_req),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    dlsc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_head         (head),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_line_end     (o_line_end),
        .o_is_directive (o_is_directive),
        .o_line_count   (o_line_count),
        .o_run_last     (o_run_last)
    );

endmodule
`default_nettype wire

// ===== sv/dlsc_front.sv =====
// Front end: comment/splice scanner state, classifies each byte into queue entries.
`default_nettype none
module dlsc_front #(
    parameter int LINE_COUNT_BITS = 24
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_char_byte,
    input  wire logic             i_end_of_file,
    output logic                  o_push,
    output dlsc_pkg::t_entry      o_entry
);

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [LINE_COUNT_BITS-1:0] COUNT_MAX = {LINE_COUNT_BITS{1'b1}};

    typedef enum logic [2:0] {
        MD_NORMAL = 3'b001,
        MD_BLOCK  = 3'b010,
        MD_LINE   = 3'b100
    } t_mode;

    typedef enum logic [3:0] {
        HK_NONE  = 4'b0001,
        HK_SLASH = 4'b0010,
        HK_BSL   = 4'b0100,
        HK_STAR  = 4'b1000
    } t_held;

    typedef enum logic [3:0] {
        PH_BLANK = 4'b0001,
        PH_HASH  = 4'b0010,
        PH_DIR   = 4'b0100,
        PH_NOT   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic   le;
        logic   dir;
        t_phase phase;
    } t_nc;

    function automatic t_nc normal_char(input t_phase ph, input logic [7:0] b);
        t_nc r;
        r.le    = (b == CH_NL);
        r.dir   = r.le && (ph == PH_DIR);
        r.phase = ph;
        if (r.le) begin
            r.phase = PH_BLANK;
        end else if (b != CH_SP && b != CH_TAB) begin
            unique case (ph)
                PH_BLANK: r.phase = (b == CH_HASH) ? PH_HASH : PH_NOT;
                PH_HASH:  r.phase = PH_DIR;
                default:  r.phase = ph;
            endcase
        end
        return r;
    endfunction

    function automatic dlsc_pkg::t_res mk_res(input logic [7:0] b, input logic le,
                                              input logic dir);
        dlsc_pkg::t_res r;
        r.out_byte     = b;
        r.line_end     = le;
        r.is_directive = dir;
        return r;
    endfunction

    t_mode                      r_mode, n_mode;
    t_held                      r_held, n_held;
    t_phase                     r_phase, n_phase;
    logic [LINE_COUNT_BITS-1:0] r_total, n_total;

    always_comb begin
        t_nc            nc;
        logic           nl;
        logic [1:0]     cnt;
        dlsc_pkg::t_res res [2];
        logic           emit_held;
        logic [7:0]     held_char;
        logic           do_plain;
        logic [7:0]     x;

        n_mode    = r_mode;
        n_held    = r_held;
        n_phase   = r_phase;
        nl        = 1'b0;
        cnt       = 2'd0;
        res[0]    = '0;
        res[1]    = '0;
        nc        = '0;
        emit_held = 1'b0;
        held_char = CH_SLASH;
        do_plain  = 1'b0;
        x         = CH_SLASH;

        unique case (r_mode)
            MD_BLOCK: begin
                nl          = (i_char_byte == CH_NL);
                res[cnt[0]] = mk_res(CH_SP, 1'b0, 1'b0);
                cnt         = cnt + 2'd1;
                if (r_held == HK_STAR && i_char_byte == CH_SLASH) begin
                    n_mode = MD_NORMAL;
                    n_held = HK_NONE;
                end else begin
                    n_held = (i_char_byte == CH_STAR) ? HK_STAR : HK_NONE;
                end
            end
            MD_LINE: begin
                if (i_char_byte == CH_NL) begin
                    n_mode   = MD_NORMAL;
                    do_plain = 1'b1;
                end else begin
                    res[cnt[0]] = mk_res(CH_SP, 1'b0, 1'b0);
                    cnt         = cnt + 2'd1;
                end
            end
            default: begin
                n_held = HK_NONE;
                unique case (r_held)
                    HK_SLASH: begin
                        if (i_char_byte == CH_STAR || i_char_byte == CH_SLASH) begin
                            res[0] = mk_res(CH_SP, 1'b0, 1'b0);
                            res[1] = mk_res(CH_SP, 1'b0, 1'b0);
                            cnt    = 2'd2;
                            n_mode = (i_char_byte == CH_STAR) ? MD_BLOCK : MD_LINE;
                        end else begin
                            emit_held = 1'b1;
                            held_char = CH_SLASH;
                            do_plain  = 1'b1;
                        end
                    end
                    HK_BSL: begin
                        if (i_char_byte == CH_NL) begin
                            // line splice
                            nl     = 1'b1;
                            res[0] = mk_res(CH_SP, 1'b0, 1'b0);
                            res[1] = mk_res(CH_SP, 1'b0, 1'b0);
                            cnt    = 2'd2;
                        end else begin
                            emit_held = 1'b1;
                            held_char = CH_BSL;
                            do_plain  = 1'b1;
                        end
                    end
                    default: do_plain = 1'b1;
                endcase
            end
        endcase

        if (emit_held) begin
            nc          = normal_char(n_phase, held_char);
            n_phase     = nc.phase;
            nl          = nl | nc.le;
            res[cnt[0]] = mk_res(held_char, nc.le, nc.dir);
            cnt         = cnt + 2'd1;
        end

        if (do_plain) begin
            if (i_char_byte == CH_SLASH) begin
                n_held = HK_SLASH;
            end else if (i_char_byte == CH_BSL) begin
                n_held = HK_BSL;
            end else begin
                nc          = normal_char(n_phase, i_char_byte);
                n_phase     = nc.phase;
                nl          = nl | nc.le;
                res[cnt[0]] = mk_res(i_char_byte, nc.le, nc.dir);
                cnt         = cnt + 2'd1;
            end
        end

        // end of file: flush the held lookahead byte, close an open line
        if (i_end_of_file) begin
            if (n_held == HK_SLASH || n_held == HK_BSL) begin
                x           = (n_held == HK_SLASH) ? CH_SLASH : CH_BSL;
                nc          = normal_char(n_phase, x);
                n_phase     = nc.phase;
                nl          = nl | nc.le;
                res[cnt[0]] = mk_res(x, nc.le, nc.dir);
                cnt         = cnt + 2'd1;
                n_held      = HK_NONE;
            end
            if (cnt != 2'd0 && !res[cnt[1]].line_end) begin
                res[cnt[1]].line_end     = 1'b1;
                res[cnt[1]].is_directive = (n_phase == PH_DIR);
            end
        end

        n_total = (nl && r_total != COUNT_MAX) ? r_total + LINE_COUNT_BITS'(1) : r_total;

        o_push             = (cnt != 2'd0);
        o_entry.two        = cnt[1];
        o_entry.res0       = res[0];
        o_entry.res1       = res[1];
        o_entry.line_count = dlsc_pkg::OUT_COUNT_BITS'(n_total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MD_NORMAL;
            r_held  <= HK_NONE;
            r_phase <= PH_BLANK;
            r_total <= '0;
        end else if (i_accept) begin
            if (i_end_of_file) begin
                r_mode  <= MD_NORMAL;
                r_held  <= HK_NONE;
                r_phase <= PH_BLANK;
                r_total <= '0;
            end else begin
                r_mode  <= n_mode;
                r_held  <= n_held;
                r_phase <= n_phase;
                r_total <= n_total;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/dlsc_queue.sv =====
// Short FIFO of classified entries between the front end and the output stage.
`default_nettype none
module dlsc_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire dlsc_pkg::t_entry  i_entry,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_empty,
    output dlsc_pkg::t_entry       o_head
);

    localparam int PB = dlsc_pkg::QUEUE_PTR_BITS;
    localparam int CB = dlsc_pkg::QUEUE_CNT_BITS;

    dlsc_pkg::t_entry r_mem [dlsc_pkg::QUEUE_DEPTH];
    logic [PB-1:0]    r_wr, r_rd;
    logic [CB-1:0]    r_cnt;

    assign o_full  = (r_cnt == CB'(dlsc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PB'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PB'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CB'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CB'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/dlsc_back.sv =====
// Output stage: splits queue entries into single results behind an output register.
`default_nettype none
module dlsc_back (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_empty,
    input  wire dlsc_pkg::t_entry                      i_head,
    output logic                                       o_pop,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [7:0]                                 o_out_byte,
    output logic                                       o_line_end,
    output logic                                       o_is_directive,
    output logic [dlsc_pkg::OUT_COUNT_BITS-1:0]        o_line_count,
    output logic                                       o_run_last
);

    logic           r_valid;
    logic           r_sub;
    dlsc_pkg::t_res r_res;
    logic [dlsc_pkg::OUT_COUNT_BITS-1:0] r_count;
    logic           r_last;

    logic           load;
    logic           last;
    dlsc_pkg::t_res sel;

    assign load  = !i_empty && (!r_valid || i_out_ready);
    assign last  = !i_head.two || r_sub;
    assign sel   = r_sub ? i_head.res1 : i_head.res0;
    assign o_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sub   <= !last;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res   <= sel;
            r_count <= i_head.line_count;
            r_last  <= last;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_out_byte     = r_res.out_byte;
    assign o_line_end     = r_res.line_end;
    assign o_is_directive = r_res.is_directive;
    assign o_line_count   = r_count;
    assign o_run_last     = r_last;

endmodule
`default_nettype wire
